/* rtl/record_field_splitter_macros.svh */
// Assertion macros for the record field splitter.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef RECORD_FIELD_SPLITTER_MACROS_SVH
`define RECORD_FIELD_SPLITTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RFS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rfs_pkg.sv */
// Shared types and constants of the record field splitter.
// No dependencies.
package rfs_pkg;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam logic [7:0] SEP_WHITESPACE = 8'd0;

    localparam logic [5:0] MAX_FIELDS = 6'd40;
    localparam logic [7:0] MAX_LINE   = 8'd255;

    localparam logic [31:0] REC_NUM_MAX = 32'hFFFF_FFFF;

    localparam logic KIND_FIELD  = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    // Work left by one input byte: an optional field beat, then an optional record beat.
    typedef struct packed {
        logic        fld_vld;
        logic [5:0]  fld_idx;
        logic [7:0]  fld_start;
        logic [7:0]  fld_len;
        logic        rec_vld;
        logic [5:0]  rec_cnt;
        logic [31:0] rec_num;
    } t_entry;

endpackage

/* rtl/rfs_front.sv */
// Front end of the record field splitter: classifies each byte and tracks line state.
// Depends on rfs_pkg.
module rfs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_data_byte,
    input  logic            i_end_of_input,
    input  logic [7:0]      i_separator,
    output logic            o_push,
    output rfs_pkg::t_entry o_entry
);

    logic [7:0]  r_kept_len, n_kept_len;
    logic [7:0]  r_cur_start, n_cur_start;
    logic        r_inside, n_inside;
    logic [5:0]  r_fields, n_fields;
    logic [31:0] r_rec_cnt, n_rec_cnt;
    logic        r_open, n_open;
    logic        r_closed, n_closed;

    logic [31:0] rec_next;
    logic        emit_req;
    logic [7:0]  emit_start;
    logic        do_close;
    logic        byte_kept;
    logic        is_blank;
    logic        fld_ok;
    rfs_pkg::t_entry entry;

    assign rec_next  = (r_rec_cnt == rfs_pkg::REC_NUM_MAX) ? r_rec_cnt : r_rec_cnt + 32'd1;
    assign fld_ok    = r_fields < rfs_pkg::MAX_FIELDS;
    assign is_blank  = (i_data_byte == rfs_pkg::CH_SPACE) || (i_data_byte == rfs_pkg::CH_TAB);
    assign byte_kept = (i_data_byte != rfs_pkg::CH_CR) && !r_closed
                     && (r_kept_len < rfs_pkg::MAX_LINE);

    always_comb begin
        n_kept_len  = r_kept_len;
        n_cur_start = r_cur_start;
        n_inside    = r_inside;
        n_fields    = r_fields;
        n_rec_cnt   = r_rec_cnt;
        n_open      = r_open;
        n_closed    = r_closed;
        emit_req    = 1'b0;
        emit_start  = r_cur_start;
        do_close    = 1'b0;

        if (i_end_of_input) begin
            do_close = r_open;
        end else if (i_data_byte == rfs_pkg::CH_LF) begin
            do_close = 1'b1;
        end else begin
            n_open = 1'b1;
            if (byte_kept) begin
                if (i_data_byte == rfs_pkg::CH_NUL) begin
                    n_closed = 1'b1;
                end else begin
                    if (i_separator == rfs_pkg::SEP_WHITESPACE) begin
                        if (is_blank) begin
                            if (r_inside) begin
                                emit_req = 1'b1;
                                n_inside = 1'b0;
                            end
                        end else if (!r_inside) begin
                            n_inside    = 1'b1;
                            n_cur_start = r_kept_len;
                        end
                    end else if (i_data_byte == i_separator) begin
                        emit_req    = 1'b1;
                        n_cur_start = r_kept_len + 8'd1;
                    end
                    n_kept_len = r_kept_len + 8'd1;
                end
            end
        end

        // Close emits the pending field first, then the record.
        if (do_close) begin
            emit_req = (i_separator != rfs_pkg::SEP_WHITESPACE) || r_inside;
        end

        entry.fld_vld   = emit_req && fld_ok;
        entry.fld_idx   = r_fields + 6'd1;
        entry.fld_start = emit_start;
        entry.fld_len   = r_kept_len - r_cur_start;
        entry.rec_vld   = do_close;
        entry.rec_cnt   = r_fields + {5'd0, entry.fld_vld};
        entry.rec_num   = rec_next;

        if (entry.fld_vld) begin
            n_fields = r_fields + 6'd1;
        end

        if (do_close) begin
            n_rec_cnt   = rec_next;
            n_kept_len  = 8'd0;
            n_cur_start = 8'd0;
            n_inside    = 1'b0;
            n_fields    = 6'd0;
            n_open      = 1'b0;
            n_closed    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept_len  <= 8'd0;
            r_cur_start <= 8'd0;
            r_inside    <= 1'b0;
            r_fields    <= 6'd0;
            r_rec_cnt   <= 32'd0;
            r_open      <= 1'b0;
            r_closed    <= 1'b0;
        end else if (i_accept) begin
            r_kept_len  <= n_kept_len;
            r_cur_start <= n_cur_start;
            r_inside    <= n_inside;
            r_fields    <= n_fields;
            r_rec_cnt   <= n_rec_cnt;
            r_open      <= n_open;
            r_closed    <= n_closed;
        end
    end

    // Push only bytes that leave at least one beat.
    assign o_push  = i_accept && (entry.fld_vld || entry.rec_vld);
    assign o_entry = entry;

endmodule

/* rtl/rfs_queue.sv */
// Short work queue between the front and back ends of the record field splitter.
// Depends on rfs_pkg.
module rfs_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rfs_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output rfs_pkg::t_entry o_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    rfs_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;

    assign n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + AW'(1);
    assign n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + AW'(1);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    assign o_full  = r_count == FULL_CNT;
    assign o_valid = r_count != '0;
    assign o_entry = r_mem[r_rd_ptr];

endmodule

/* rtl/rfs_back.sv */
// Back end of the record field splitter: expands each queued entry into result beats.
// Depends on rfs_pkg.
module rfs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  rfs_pkg::t_entry i_entry,
    output logic            o_deq,
    output logic            o_empty,
    input  logic            i_pop,
    output logic            o_kind,
    output logic [5:0]      o_field_index,
    output logic [7:0]      o_field_start,
    output logic [7:0]      o_field_length,
    output logic [5:0]      o_field_count,
    output logic [31:0]     o_record_number,
    output logic            o_last_of_run
);

    // Set once the field beat of a two-beat entry has gone out.
    logic r_fld_done;
    logic show_fld;
    logic take;

    assign show_fld = i_entry.fld_vld && !r_fld_done;
    assign o_empty  = !i_valid;
    assign take     = i_pop && i_valid;
    assign o_deq    = take && !(show_fld && i_entry.rec_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fld_done <= 1'b0;
        end else if (take) begin
            r_fld_done <= show_fld && i_entry.rec_vld;
        end
    end

    always_comb begin
        if (show_fld) begin
            o_kind          = rfs_pkg::KIND_FIELD;
            o_field_index   = i_entry.fld_idx;
            o_field_start   = i_entry.fld_start;
            o_field_length  = i_entry.fld_len;
            o_field_count   = 6'd0;
            o_last_of_run   = !i_entry.rec_vld;
        end else begin
            o_kind          = rfs_pkg::KIND_RECORD;
            o_field_index   = 6'd0;
            o_field_start   = 8'd0;
            o_field_length  = 8'd0;
            o_field_count   = i_entry.rec_cnt;
            o_last_of_run   = 1'b1;
        end
        o_record_number = i_entry.rec_num;
    end

endmodule

/* rtl/record_field_splitter.sv */
// Record field splitter top level. Entries for accepted bytes pass through the registered work queue.
// Throughput: 1 byte per cycle while full is low; a close (LF or end of stream) that also ends a field takes
// 2 output beats. The queue of QUEUE_DEPTH entries absorbs those and output stalls.
// Reset (i_rst_n low, synchronous) clears line state, the record count, the queue
// and the separator register (whitespace mode).
// Depends on rfs_pkg, rfs_front, rfs_queue, rfs_back and record_field_splitter_macros.svh.
`include "record_field_splitter_macros.svh"

module record_field_splitter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte input, queue style
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_input,
    // Separator register write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    // Result output, queue style
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [5:0]  o_field_index,
    output logic [7:0]  o_field_start,
    output logic [7:0]  o_field_length,
    output logic [5:0]  o_field_count,
    output logic [31:0] o_record_number,
    output logic        o_last_of_run
);

    logic [7:0]      r_separator;
    logic            accept;
    logic            q_push;
    logic            q_full;
    logic            q_valid;
    logic            q_deq;
    rfs_pkg::t_entry q_in;
    rfs_pkg::t_entry q_head;
    logic            fld_beat;
    logic            rec_beat;
    logic            fld_mid;

    // Separator register: always ready; the user writes it only while the block is idle, which goes unchecked.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_separator <= rfs_pkg::SEP_WHITESPACE;
        end else if (i_cfg_valid) begin
            r_separator <= i_cfg_data;
        end
    end

    // Hold off the byte stream only when the work queue has no free slot.
    assign full   = q_full;
    assign accept = push && !q_full;

    // Front end: classify each byte, update line state, enqueue beats it causes.
    rfs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_end_of_input (i_end_of_input),
        .i_separator    (r_separator),
        .o_push         (q_push),
        .o_entry        (q_in)
    );

    // Work queue decouples byte intake from beat delivery.
    rfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_deq),
        .o_valid (q_valid),
        .o_entry (q_head)
    );

    // Back end: drive the field beat, then the record beat, of the head entry.
    rfs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_entry         (q_head),
        .o_deq           (q_deq),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_kind          (o_kind),
        .o_field_index   (o_field_index),
        .o_field_start   (o_field_start),
        .o_field_length  (o_field_length),
        .o_field_count   (o_field_count),
        .o_record_number (o_record_number),
        .o_last_of_run   (o_last_of_run)
    );

    // Result side views for the checks below.
    assign fld_beat = !empty && (o_kind == rfs_pkg::KIND_FIELD);
    assign rec_beat = !empty && (o_kind == rfs_pkg::KIND_RECORD);
    assign fld_mid  = pop && fld_beat && !o_last_of_run;

    // A field beat always carries a nonzero field number.
    `RFS_ASSERT_IMPL(a_field_index_nonzero, fld_beat, o_field_index != 6'd0, "zero field index")
    // A field beat that does not end its run is followed by that run's record beat.
    `RFS_ASSERT_NEXT(a_record_follows, fld_mid, rec_beat, "record beat missing")
    // The front end never pushes into a full queue.
    `RFS_ASSERT_IMPL(a_no_push_when_full, q_push, !q_full, "push into full work queue")

endmodule
